// File: rtl/rds_pkg.sv
`timescale 1ns / 1ps

package rds_pkg;

  // default sizing
  localparam int DEF_TABLE_DEPTH  = 1024;
  localparam int DEF_HANDLE_WIDTH = 32;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int RAND_W   = 32;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 16;

  // register port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DRAW    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DRAWN     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESTARTED = 3'd4;

  // register indexes (word address)
  localparam logic [1:0] REG_WITH_REPL = 2'd0;
  localparam logic [1:0] REG_USE_LIMIT = 2'd1;
  localparam logic [1:0] REG_LIMIT     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] entry_value;
    logic [RAND_W-1:0]  random_word;
  } request_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  drawn_value;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAST,
    S_DIV,
    S_PICK
  } state_t;

endpackage

// File: rtl/random_draw_shuffler.sv
`timescale 1ns / 1ps

// Shuffle table with one command request at a time: load, draw or restart.
// A request is taken when start is high and busy is low; its one result shows
// on result for a single cycle with done high and cannot be held off, so the
// receiver must take it then. Load, restart and refused draws answer in the
// cycle after the request and busy never rises for them. A successful draw
// runs 32 steps of the bit-serial remainder unit that reduces the random word
// by the live (or loaded) count, with the last live entry read as the unit
// starts, then reads the picked slot and in S_PICK does the write-back (without
// replacement) and the result; busy is high in the S_LAST, S_DIV and S_PICK states.
// There is no clearing pass after reset; the table is only read below the
// loaded count.
module random_draw_shuffler #(
  parameter int TABLE_DEPTH  = rds_pkg::DEF_TABLE_DEPTH,
  parameter int HANDLE_WIDTH = rds_pkg::DEF_HANDLE_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  rds_pkg::request_t               request,
  output logic                            done,
  output rds_pkg::result_t                result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rds_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rds_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rds_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rds_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic               with_repl;
  logic               use_limit;
  logic [LIMIT_W-1:0] draw_limit;

  logic [CNT_W-1:0]   loaded_count, loaded_count_next;
  logic [CNT_W-1:0]   live_count, live_count_next;
  logic [LIMIT_W-1:0] draws_done, draws_done_next;
  logic               drawing_started, drawing_started_next;
  logic               done_next;
  result_t            result_next;

  logic [HANDLE_WIDTH-1:0] last_value;
  logic [CNT_W-1:0]        live_last;
  logic [CNT_W-1:0]        pool;
  logic                    limit_hit;
  logic                    accept;

  logic                    wr_en, rd_en;
  logic [IDX_W-1:0]        wr_addr, rd_addr;
  logic [HANDLE_WIDTH-1:0] wr_data, rd_data;

  logic             div_start;
  logic             div_done;
  logic [CNT_W-1:0] div_rem;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      with_repl  <= 1'b0;
      use_limit  <= 1'b0;
      draw_limit <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[CFG_ADDR_W-1:2])
        REG_WITH_REPL: with_repl  <= pwdata[0];
        REG_USE_LIMIT: use_limit  <= pwdata[0];
        REG_LIMIT:     draw_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[CFG_ADDR_W-1:2])
      REG_WITH_REPL: prdata = CFG_DATA_W'(with_repl);
      REG_USE_LIMIT: prdata = CFG_DATA_W'(use_limit);
      REG_LIMIT:     prdata = CFG_DATA_W'(draw_limit);
      default:       prdata = '0;
    endcase
  end

  // entry table
  rds_table #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(HANDLE_WIDTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // shared remainder unit
  rds_mod_unit #(
    .CNT_W(CNT_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (request.random_word),
    .divisor  (pool),
    .done     (div_done),
    .remainder(div_rem)
  );

  // request decode helpers
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign live_last = live_count - 1'b1;
  assign pool      = with_repl ? loaded_count : live_count;
  assign limit_hit = use_limit && (draws_done >= draw_limit);

  // sequencer: next state, memory control and result
  always_comb begin
    state_next           = state;
    loaded_count_next    = loaded_count;
    live_count_next      = live_count;
    draws_done_next      = draws_done;
    drawing_started_next = drawing_started;
    done_next            = 1'b0;
    result_next          = '0;
    wr_en                = 1'b0;
    wr_addr              = loaded_count[IDX_W-1:0];
    wr_data              = HANDLE_WIDTH'(request.entry_value);
    rd_en                = 1'b0;
    rd_addr              = live_last[IDX_W-1:0];
    div_start            = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (request.command)
            CMD_LOAD: begin
              done_next = 1'b1;
              if (drawing_started || (loaded_count >= CNT_W'(TABLE_DEPTH))) begin
                result_next.status = ST_REJECTED;
              end else begin
                wr_en              = 1'b1;
                loaded_count_next  = loaded_count + 1'b1;
                live_count_next    = live_count + 1'b1;
                result_next.status = ST_LOADED;
              end
            end
            CMD_DRAW: begin
              if (limit_hit || (pool == '0)) begin
                done_next          = 1'b1;
                result_next.status = ST_EXHAUSTED;
              end else begin
                // fetch the last live entry while the remainder runs
                rd_en      = 1'b1;
                div_start  = 1'b1;
                state_next = S_LAST;
              end
            end
            CMD_RESTART: begin
              loaded_count_next    = '0;
              live_count_next      = '0;
              draws_done_next      = '0;
              drawing_started_next = 1'b0;
              done_next            = 1'b1;
              result_next.status   = ST_RESTARTED;
            end
            default: ;
          endcase
        end
      end
      S_LAST: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          rd_en      = 1'b1;
          rd_addr    = div_rem[IDX_W-1:0];
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        done_next               = 1'b1;
        result_next.status      = ST_DRAWN;
        result_next.drawn_value = VALUE_W'(rd_data);
        drawing_started_next    = 1'b1;
        if (draws_done != {LIMIT_W{1'b1}}) begin
          draws_done_next = draws_done + 1'b1;
        end
        // fisher-yates: move the last live entry into the picked slot
        if (!with_repl) begin
          wr_en           = 1'b1;
          wr_addr         = div_rem[IDX_W-1:0];
          wr_data         = last_value;
          live_count_next = live_count - 1'b1;
        end
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      loaded_count    <= '0;
      live_count      <= '0;
      draws_done      <= '0;
      drawing_started <= 1'b0;
      done            <= 1'b0;
    end else begin
      state           <= state_next;
      loaded_count    <= loaded_count_next;
      live_count      <= live_count_next;
      draws_done      <= draws_done_next;
      drawing_started <= drawing_started_next;
      done            <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    result <= result_next;
    if (state == S_LAST) begin
      last_value <= rd_data;
    end
  end

`ifndef SYNTH
  a_live_le_loaded: assert property (@(posedge clk) disable iff (rst)
    live_count <= loaded_count)
    else $error("live count above loaded count");

  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(TABLE_DEPTH))
    else $error("loaded count above table depth");

  a_div_in_phase: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("remainder finished outside divide phase");

  a_pick_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |=> (done && (result.status == ST_DRAWN) && !busy))
    else $error("draw did not complete with a drawn result");
`endif

endmodule

// File: rtl/rds_mod_unit.sv
`timescale 1ns / 1ps

module rds_mod_unit #(
  parameter int CNT_W = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rds_pkg::RAND_W-1:0] dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic [CNT_W-1:0]          remainder
);
  import rds_pkg::*;

  localparam int STEP_W = $clog2(RAND_W + 1);

  logic              run;
  logic [STEP_W-1:0] steps;
  logic [RAND_W-1:0] dq;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  rem_step;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {remainder, dq[RAND_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (shifted >= {1'b0, dvs}) begin
      rem_step = diff[CNT_W-1:0];
    end else begin
      rem_step = shifted[CNT_W-1:0];
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        steps <= STEP_W'(RAND_W);
      end else if (run) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dq        <= dividend;
      dvs       <= divisor;
    end else if (run) begin
      remainder <= rem_step;
      dq        <= {dq[RAND_W-2:0], 1'b0};
    end
  end

endmodule

// File: rtl/rds_table.sv
`timescale 1ns / 1ps

module rds_table #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: dv/tb_random_draw_shuffler.sv
`timescale 1ns / 1ps

module tb_random_draw_shuffler;
  import rds_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int ITEM_GOAL = 1650;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS = 60;
  localparam int FULL_PHASE = 5;
  localparam int CALM_FROM = 250;
  localparam int CALM_TO = 450;
  localparam int MAX_PRINTS = 40;

  // the one command code the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic {
    STEP_REQUEST,
    STEP_REGISTER
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  code;
    logic [31:0] value;
    logic [31:0] rnd;
    bit          typed;
    result_t     typed_result;
  } directed_step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  request_t request = '0;
  logic done;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // shadow of the shuffle table and its counters
  logic [31:0] handle_store [TABLE_DEPTH];
  int unsigned loaded_n = 0;
  int unsigned live_n = 0;
  logic [LIMIT_W-1:0] draws_n = '0;
  bit draw_begun = 1'b0;
  bit repl_mode = 1'b0;
  bit limit_on = 1'b0;
  logic [LIMIT_W-1:0] draw_cap = '0;

  result_t expected_results [$];
  directed_step_t directed_steps [$];
  int error_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int register_writes = 0;
  int full_refusals = 0;
  int status_seen [5] = '{default: 0};

  random_draw_shuffler i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  // expected answer to one request; updates the shadow state
  function automatic bit compute_shuffle_result(input request_t req, output result_t res);
    int unsigned pick_idx;
    res = '0;
    case (req.command)
      CMD_LOAD: begin
        if (draw_begun || loaded_n >= TABLE_DEPTH) begin
          if (!draw_begun) full_refusals++;
          res.status = ST_REJECTED;
        end else begin
          handle_store[loaded_n] = req.entry_value;
          loaded_n++;
          live_n++;
          res.status = ST_LOADED;
        end
      end
      CMD_DRAW: begin
        if (limit_on && draws_n >= draw_cap) begin
          res.status = ST_EXHAUSTED;
        end else if (repl_mode ? (loaded_n == 0) : (live_n == 0)) begin
          res.status = ST_EXHAUSTED;
        end else begin
          if (repl_mode) begin
            pick_idx = req.random_word % loaded_n;
            res.drawn_value = handle_store[pick_idx];
          end else begin
            // swap the last live entry into the drawn slot
            pick_idx = req.random_word % live_n;
            res.drawn_value = handle_store[pick_idx];
            handle_store[pick_idx] = handle_store[live_n - 1];
            live_n--;
          end
          if (draws_n != '1) draws_n++;
          draw_begun = 1'b1;
          res.status = ST_DRAWN;
        end
      end
      CMD_RESTART: begin
        loaded_n = 0;
        live_n = 0;
        draws_n = '0;
        draw_begun = 1'b0;
        res.status = ST_RESTARTED;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // hold start low until every pending result has been seen
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // present one request and wait for the block to take it
  task automatic issue_request(input request_t req, input bit use_typed, input result_t typed_res);
    result_t predicted;
    start <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (compute_shuffle_result(req, predicted)) begin
      expected_results.push_back(use_typed ? typed_res : predicted);
    end
    if (req.command != CMD_UNUSED) items_sent++;
  endtask

  // register write with read-back, only while the block is quiet
  task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] got;
    logic [31:0] want;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    register_writes++;
    case (idx)
      REG_WITH_REPL: begin
        repl_mode = val[0];
        want = {31'd0, val[0]};
        got = {31'd0, got[0]};
      end
      REG_USE_LIMIT: begin
        limit_on = val[0];
        want = {31'd0, val[0]};
        got = {31'd0, got[0]};
      end
      default: begin
        draw_cap = val[LIMIT_W-1:0];
        want = {16'd0, val[LIMIT_W-1:0]};
        got = {16'd0, got[LIMIT_W-1:0]};
      end
    endcase
    if (got !== want) begin
      report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, got, want));
    end
  endtask

  task automatic plan(input step_kind_t kind, input logic [1:0] code, input logic [31:0] value,
                      input logic [31:0] rnd, input bit typed, input logic [2:0] status,
                      input logic [31:0] drawn);
    directed_step_t s;
    s.kind = kind;
    s.code = code;
    s.value = value;
    s.rnd = rnd;
    s.typed = typed;
    s.typed_result.drawn_value = drawn;
    s.typed_result.status = status;
    directed_steps.push_back(s);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(19))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(31);
      3: return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // random gaps and full drains on the request side
  task automatic pace_sender();
    int gap;
    if (items_sent >= CALM_FROM && items_sent < CALM_TO) return;
    if ($urandom_range(199) == 0) wait_results_drained();
    if ($urandom_range(99) < 6) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [1:0] cmd, input bit quiet);
    request_t req;
    request_t stray;
    pace_sender();
    // stray request that breaks up the load/draw sequence
    if (!quiet && $urandom_range(99) < 5) begin
      case ($urandom_range(3))
        0: stray.command = CMD_RESTART;
        1: stray.command = CMD_LOAD;
        default: stray.command = CMD_UNUSED;
      endcase
      stray.entry_value = pick_word();
      stray.random_word = pick_word();
      issue_request(stray, 1'b0, '0);
    end
    req.command = cmd;
    req.entry_value = pick_word();
    req.random_word = pick_word();
    issue_request(req, 1'b0, '0);
  endtask

  // restart, fill, then draw, sometimes with a load after; sometimes keeps the previous table
  task automatic run_episode(input int fill, input int draw_count, input bit quiet);
    if (quiet || $urandom_range(99) < 85) send_random(CMD_RESTART, quiet);
    repeat (fill) send_random(CMD_LOAD, quiet);
    repeat (draw_count) send_random(CMD_DRAW, quiet);
    if ($urandom_range(3) == 0) send_random(CMD_LOAD, quiet);
  endtask

  task automatic configure_phase(input int phase);
    logic [31:0] repl;
    logic [31:0] lim;
    logic [31:0] cap;
    case (phase)
      0: begin repl = 0; lim = 0; cap = 0; end
      1: begin repl = 1; lim = 0; cap = 32'hFFFF; end
      2: begin repl = 0; lim = 1; cap = 32'hFFFF; end
      3: begin repl = 1; lim = 1; cap = $urandom_range(1, 8); end
      4: begin repl = 0; lim = 1; cap = 0; end
      FULL_PHASE: begin repl = 0; lim = 0; cap = 0; end
      default: begin
        repl = $urandom_range(1);
        lim = $urandom_range(1);
        cap = ($urandom_range(9) < 7) ? $urandom_range(0, 12) : $urandom_range(0, 65535);
      end
    endcase
    write_register(REG_WITH_REPL, repl);
    write_register(REG_USE_LIMIT, lim);
    write_register(REG_LIMIT, cap);
  endtask

  // result check against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d value %h",
                                  result.status, result.drawn_value));
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result.status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", result.status, want.status));
        end
        if (result.drawn_value !== want.drawn_value) begin
          report_mismatch($sformatf("drawn_value %h, expected %h",
                                    result.drawn_value, want.drawn_value));
        end
        if (result.status <= ST_RESTARTED) status_seen[result.status]++;
      end
    end
  end

  initial begin : stimulus
    request_t req;
    int phase_start;
    int fill;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, starting from the default registers after reset
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h1234_5678, 1, ST_EXHAUSTED, 0);
    plan(STEP_REQUEST, CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    plan(STEP_REQUEST, CMD_RESTART, 32'hFFFF_FFFF, 32'h0, 1, ST_RESTARTED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'h0000_0000, 32'hFFFF_FFFF, 1, ST_LOADED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'hFFFF_FFFF, 32'h0, 1, ST_LOADED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'hA5A5_A5A5, 32'h0, 1, ST_LOADED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'h5A5A_5A5A, 32'h0, 1, ST_LOADED, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'hFFFF_FFFF, 32'h0, 1, ST_DRAWN, 32'h0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
    // loading is closed once a draw went through
    plan(STEP_REQUEST, CMD_LOAD, 32'h1111_1111, 32'h0, 1, ST_REJECTED, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h0000_0001, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h8000_0000, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h7FFF_FFFF, 1, ST_EXHAUSTED, 0);
    plan(STEP_REQUEST, CMD_UNUSED, 32'h0, 32'h0, 0, 0, 0);
    plan(STEP_REQUEST, CMD_RESTART, 32'h0, 32'h0, 1, ST_RESTARTED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'h1234_5678, 32'h0, 1, ST_LOADED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'hDEAD_BEEF, 32'h0, 1, ST_LOADED, 0);
    // with replacement, then the draw limit at zero and at three
    plan(STEP_REGISTER, REG_WITH_REPL, 32'h1, 32'h0, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'hFFFF_FFFF, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h0000_0002, 0, 0, 0);
    plan(STEP_REGISTER, REG_USE_LIMIT, 32'h1, 32'h0, 0, 0, 0);
    plan(STEP_REGISTER, REG_LIMIT, 32'h0, 32'h0, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h0000_0003, 1, ST_EXHAUSTED, 0);
    plan(STEP_REGISTER, REG_LIMIT, 32'h3, 32'h0, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h0000_0005, 0, 0, 0);
    plan(STEP_REQUEST, CMD_DRAW, 32'h0, 32'h0000_0006, 1, ST_EXHAUSTED, 0);
    plan(STEP_REQUEST, CMD_LOAD, 32'h0000_0001, 32'h0, 1, ST_REJECTED, 0);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_REGISTER) begin
        write_register(directed_steps[i].code, directed_steps[i].value);
      end else begin
        req.command = directed_steps[i].code;
        req.entry_value = directed_steps[i].value;
        req.random_word = directed_steps[i].rnd;
        issue_request(req, directed_steps[i].typed, directed_steps[i].typed_result);
      end
    end

    // random part, one register setting per phase
    for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
      configure_phase(phase);
      phase_start = items_sent;
      if (phase == FULL_PHASE) begin
        run_episode(TABLE_DEPTH + 2, 24, 1'b1);
      end else begin
        while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_GOAL) begin
          fill = ($urandom_range(19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
          run_episode(fill, fill + $urandom_range(0, 3), 1'b0);
        end
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d requests, %0d results checked, %0d register writes",
             items_sent, results_checked, register_writes);
    $display("summary: %0d drawn, %0d loaded, %0d refused loads (%0d on a full table),",
             status_seen[ST_DRAWN], status_seen[ST_LOADED], status_seen[ST_REJECTED],
             full_refusals);
    $display("summary: %0d exhausted, %0d restarts",
             status_seen[ST_EXHAUSTED], status_seen[ST_RESTARTED]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_random_draw_shuffler passed");
    end else begin
      $display("%0d mismatches, %0d results still pending", error_count,
               expected_results.size());
      $display("tb_random_draw_shuffler failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #10_000_000;
    $display("timeout with %0d results pending", expected_results.size());
    $display("tb_random_draw_shuffler failed");
    $finish;
  end

endmodule
